FILE: rtl/straight_alpha_pixel_blend_defines.svh
// -----------------------------------------------------------------------------
// Straight alpha pixel blend assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef STRAIGHT_ALPHA_PIXEL_BLEND_DEFINES_SVH
`define STRAIGHT_ALPHA_PIXEL_BLEND_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SAPB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("straight_alpha_pixel_blend: assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define SAPB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("straight_alpha_pixel_blend: assertion failed");

`endif

FILE: rtl/sapb_pkg.sv
// -----------------------------------------------------------------------------
// Straight alpha pixel blend package
// Word types, register codes, reset values and the shared arithmetic helpers.
// -----------------------------------------------------------------------------
`default_nettype none

package sapb_pkg;

	localparam int MAX_PIXELS          = 4;
	localparam int PIXELS_PER_ITEM_DEF = 4;
	localparam int CFG_INDEX_W         = 3;
	localparam int CFG_DATA_W          = 32;

	localparam logic [16:0] DIV255_MUL = 17'h08081;
	localparam logic [7:0]  FULL_ALPHA = 8'hFF;

	localparam logic [1:0] MODE_OPAQUE = 2'd0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BLEND_MODE     = 3'd0,
		REG_ALPHA_BYTE     = 3'd1,
		REG_BLANKET_ALPHA  = 3'd2,
		REG_DST_OPAQUE     = 3'd3,
		REG_DST_COLOR_MASK = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] src_pair_lo;
		logic [63:0] src_pair_hi;
		logic [63:0] dst_pair_lo;
		logic [63:0] dst_pair_hi;
	} in_word_t;

	typedef struct packed {
		logic [63:0] out_pair_lo;
		logic [63:0] out_pair_hi;
	} out_word_t;

	typedef struct packed {
		logic [1:0]  blend_mode;
		logic [1:0]  alpha_byte;
		logic [7:0]  blanket_alpha;
		logic        dst_opaque;
		logic [31:0] dst_color_mask;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		blend_mode:     2'd1,
		alpha_byte:     2'd3,
		blanket_alpha:  8'hFF,
		dst_opaque:     1'b0,
		dst_color_mask: 32'h00FF_FFFF
	};

	// Exact floor division by 255 for any product of two bytes.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'(DIV255_MUL);
		return p[30:23];
	endfunction

	function automatic logic [7:0] mix_byte(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		logic [17:0] v;
		v = {2'b00, d, 8'h00} + 18'(s) * 18'({1'b0, a} + 9'd1) - 18'(d) * 18'(a);
		return v[15:8];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sapb_lane.sv
// -----------------------------------------------------------------------------
// Straight alpha pixel blend lane
// Three register stages that blend one source pixel over one destination pixel.
// -----------------------------------------------------------------------------
`default_nettype none

module sapb_lane
	import sapb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        adv,
	input  wire cfg_t        cfg,
	input  wire logic [31:0] src,
	input  wire logic [31:0] dst,
	output logic      [31:0] pix
);

	logic [4:0]  abit;
	logic [7:0]  sa_in;
	logic [7:0]  da_in;

	logic [31:0] src_s1, dst_s1, src_s2, dst_s2, src_s3, dst_s3;
	logic [7:0]  sa_s1, da_s1, sa_s2, da_s2, sa_s3, da_s3, wgt_s3;
	logic [15:0] prod_s1, prod_s3;

	logic [8:0]  alpha_sum;
	logic [31:0] mixed;

	assign abit  = {cfg.alpha_byte, 3'b000};
	assign sa_in = src[abit +: 8];
	assign da_in = dst[abit +: 8];

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1  <= src;
			dst_s1  <= dst;
			sa_s1   <= sa_in;
			da_s1   <= da_in;
			prod_s1 <= 16'(sa_in) * 16'(cfg.blanket_alpha);

			src_s2  <= src_s1;
			dst_s2  <= dst_s1;
			sa_s2   <= cfg.blend_mode[1] ? div255(prod_s1) : sa_s1;
			da_s2   <= (cfg.blend_mode[1] && cfg.dst_opaque) ? FULL_ALPHA : da_s1;

			src_s3  <= src_s2;
			dst_s3  <= dst_s2;
			sa_s3   <= sa_s2;
			da_s3   <= da_s2;
			prod_s3 <= 16'(sa_s2) * 16'(da_s2);
			wgt_s3  <= (cfg.blend_mode != MODE_OPAQUE && da_s2 == 8'h00) ? FULL_ALPHA : sa_s2;
		end
	end

	always_comb begin
		alpha_sum = {1'b0, sa_s3} + {1'b0, da_s3} - {1'b0, div255(prod_s3)};
		for (int k = 0; k < 4; k++) begin
			mixed[8*k +: 8] = mix_byte(src_s3[8*k +: 8], dst_s3[8*k +: 8], wgt_s3);
		end
		if (cfg.blend_mode == MODE_OPAQUE) begin
			pix = mixed & cfg.dst_color_mask;
		end else begin
			pix = mixed;
			for (int k = 0; k < 4; k++) begin
				if (cfg.alpha_byte == 2'(k)) begin
					pix[8*k +: 8] = alpha_sum[7:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sapb_merge.sv
// -----------------------------------------------------------------------------
// Straight alpha pixel blend merge stage
// Input skid word, pipeline valid tracking and the packed output register.
// -----------------------------------------------------------------------------
`default_nettype none

module sapb_merge
	import sapb_pkg::*;
#(
	parameter int LANES = MAX_PIXELS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire in_word_t              item_word,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output out_word_t                  res_word,
	input  wire logic [LANES-1:0][31:0] lane_pix,
	output logic                       adv,
	output in_word_t                   entry
);

	in_word_t         skid_q;
	logic             skid_vld_q;
	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic             entry_vld;
	logic [3:0][31:0] pix4;
	out_word_t        res_s4;

	for (genvar g = 0; g < 4; g++) begin : g_pack
		if (g < LANES) begin : g_used
			assign pix4[g] = lane_pix[g];
		end else begin : g_zero
			assign pix4[g] = '0;
		end
	end

	assign adv        = !(vld_s4 && res_stall);
	assign entry      = skid_vld_q ? skid_q : item_word;
	assign entry_vld  = skid_vld_q || item_valid;
	assign item_stall = skid_vld_q;
	assign res_valid  = vld_s4;
	assign res_word   = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
		end else if (adv) begin
			skid_vld_q <= 1'b0;
			vld_s1     <= entry_vld;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
		end else if (item_valid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && item_valid && !skid_vld_q) begin
			skid_q <= item_word;
		end
		if (adv) begin
			res_s4.out_pair_lo <= {pix4[1], pix4[0]};
			res_s4.out_pair_hi <= {pix4[3], pix4[2]};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/straight_alpha_pixel_blend.sv
// -----------------------------------------------------------------------------
// Straight alpha pixel blend, top level
// Throughput is one word per cycle while the output is not stalled; every lane
// and the merge register advance together, and a one-word skid lets the input
// stall flag come from a register. Reset clears all valid flags and returns
// the configuration registers to their reset values.
// -----------------------------------------------------------------------------
`default_nettype none

module straight_alpha_pixel_blend
	import sapb_pkg::*;
#(
	parameter int PIXELS_PER_ITEM = PIXELS_PER_ITEM_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire in_word_t               item_word,
	output logic                        res_valid,
	input  wire logic                   res_stall,
	output out_word_t                   res_word,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int LANES = (PIXELS_PER_ITEM < MAX_PIXELS) ? PIXELS_PER_ITEM : MAX_PIXELS;

	cfg_t                   cfg_q;
	logic                   adv;
	in_word_t               entry;
	logic [LANES-1:0][31:0] lane_pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLEND_MODE:     cfg_q.blend_mode     <= cfg_data[1:0];
				REG_ALPHA_BYTE:     cfg_q.alpha_byte     <= cfg_data[1:0];
				REG_BLANKET_ALPHA:  cfg_q.blanket_alpha  <= cfg_data[7:0];
				REG_DST_OPAQUE:     cfg_q.dst_opaque     <= cfg_data[0];
				REG_DST_COLOR_MASK: cfg_q.dst_color_mask <= cfg_data[31:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic [31:0] src_pix;
		logic [31:0] dst_pix;

		if ((g / 2) == 0) begin : g_lo
			assign src_pix = entry.src_pair_lo[32*(g%2) +: 32];
			assign dst_pix = entry.dst_pair_lo[32*(g%2) +: 32];
		end else begin : g_hi
			assign src_pix = entry.src_pair_hi[32*(g%2) +: 32];
			assign dst_pix = entry.dst_pair_hi[32*(g%2) +: 32];
		end

		sapb_lane u_lane (
			.clk (clk),
			.adv (adv),
			.cfg (cfg_q),
			.src (src_pix),
			.dst (dst_pix),
			.pix (lane_pix[g])
		);
	end

	sapb_merge #(
		.LANES (LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_word  (item_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word),
		.lane_pix   (lane_pix),
		.adv        (adv),
		.entry      (entry)
	);

endmodule

`default_nettype wire

FILE: rtl/sapb_checker.sv
// -----------------------------------------------------------------------------
// Straight alpha pixel blend checker
// Port-level checks on result timing, stall behavior and the output hold.
// -----------------------------------------------------------------------------
`default_nettype none

`include "straight_alpha_pixel_blend_defines.svh"

module sapb_checker
	import sapb_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   item_valid,
	input wire logic                   item_stall,
	input wire in_word_t               item_word,
	input wire logic                   res_valid,
	input wire logic                   res_stall,
	input wire out_word_t              res_word,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic acc;
	logic unused_ok;

	assign acc       = item_valid && !item_stall;
	assign unused_ok = ^{item_word, cfg_valid, cfg_index, cfg_data};

	`SAPB_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid)
	`SAPB_ASSERT_NEXT(a_word_held, res_valid && res_stall, $stable(res_word))
	`SAPB_ASSERT_NEXT(a_latency, (acc && !res_stall) ##1 !res_stall ##1 !res_stall ##1 !res_stall, res_valid)
	`SAPB_ASSERT_NOW(a_stall_cause, $rose(item_stall), $past(res_valid && res_stall) && cfg_ready)

endmodule

bind straight_alpha_pixel_blend sapb_checker u_sapb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.item_word  (item_word),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_word   (res_word),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data)
);

`default_nettype wire

FILE: verif/tb_top.sv
// -----------------------------------------------------------------------------
// Straight alpha pixel blend testbench
// Drives words of four source and four destination pixels through the blender
// under every blend mode and alpha position and random register settings. A
// predictor in this file computes each blended word, and a checker compares
// every result word with the oldest one predicted. Both sides idle in random
// bursts, except in the final two phases and in some randomly chosen phases.
// -----------------------------------------------------------------------------
module tb_top;
	import sapb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIXELS          = PIXELS_PER_ITEM_DEF;
	localparam int RAND_PHASES     = 16;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 16;

	localparam logic [3:0][31:0] EDGE_SRC = {32'h01000000, 32'h80FFFFFF,
		32'hFF102030, 32'h00FF8040};
	localparam logic [3:0][31:0] EDGE_DST = {32'h7F808080, 32'hFF00FF00,
		32'h00ABCDEF, 32'h00123456};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	in_word_t               item_word;
	logic                   res_valid;
	logic                   res_stall;
	out_word_t              res_word;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	cfg_t      blend_cfg;
	out_word_t pending_blends[$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	bit        quiet = 1'b0;

	straight_alpha_pixel_blend #(
		.PIXELS_PER_ITEM(PIXELS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_word (item_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] lerp_channel(input int s, input int d, input int a);
		int v;
		v = (d << 8) + (s - d) * a + s;
		return v[15:8];
	endfunction

	function automatic logic [31:0] blended_pixel(input logic [31:0] src,
			input logic [31:0] dst);
		int sh;
		int sa;
		int da;
		int na;
		int wt;
		logic [31:0] px;
		sh = 8 * int'(blend_cfg.alpha_byte);
		sa = src[sh +: 8];
		da = dst[sh +: 8];
		px = '0;
		if (blend_cfg.blend_mode == MODE_OPAQUE) begin
			for (int k = 0; k < 4; k++)
				px[8*k +: 8] = lerp_channel(src[8*k +: 8], dst[8*k +: 8], sa);
			return px & blend_cfg.dst_color_mask;
		end
		if (blend_cfg.blend_mode[1]) begin
			sa = sa * int'(blend_cfg.blanket_alpha) / int'(FULL_ALPHA);
			if (blend_cfg.dst_opaque)
				da = int'(FULL_ALPHA);
		end
		na = sa + da - sa * da / int'(FULL_ALPHA);
		wt = (da == 0) ? int'(FULL_ALPHA) : sa;
		for (int k = 0; k < 4; k++) begin
			if (8 * k == sh)
				px[8*k +: 8] = na[7:0];
			else
				px[8*k +: 8] = lerp_channel(src[8*k +: 8], dst[8*k +: 8], wt);
		end
		return px;
	endfunction

	function automatic out_word_t blended_word(input in_word_t w);
		logic [3:0][31:0] sp;
		logic [3:0][31:0] dp;
		logic [3:0][31:0] op;
		out_word_t r;
		sp = {w.src_pair_hi, w.src_pair_lo};
		dp = {w.dst_pair_hi, w.dst_pair_lo};
		op = '0;
		for (int i = 0; i < 4 && i < PIXELS; i++)
			op[i] = blended_pixel(sp[i], dp[i]);
		r.out_pair_lo = op[1:0];
		r.out_pair_hi = op[3:2];
		return r;
	endfunction

	function automatic logic [31:0] random_pixel();
		int sh;
		logic [31:0] px;
		sh = 8 * int'(blend_cfg.alpha_byte);
		px = $urandom;
		case ($urandom_range(0, 7))
			0: px[sh +: 8] = 8'h00;
			1: px[sh +: 8] = FULL_ALPHA;
			default: ;
		endcase
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_pixels(input logic [3:0][31:0] src, input logic [3:0][31:0] dst);
		in_word_t w;
		int gap;
		w.src_pair_lo = src[1:0];
		w.src_pair_hi = src[3:2];
		w.dst_pair_lo = dst[1:0];
		w.dst_pair_hi = dst[3:2];
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_word <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_blends.push_back(blended_word(w));
	endtask

	task automatic send_random_pixels();
		logic [3:0][31:0] s;
		logic [3:0][31:0] d;
		for (int i = 0; i < 4; i++) begin
			s[i] = random_pixel();
			d[i] = random_pixel();
		end
		send_pixels(s, d);
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_blends.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BLEND_MODE:     blend_cfg.blend_mode = data[1:0];
			REG_ALPHA_BYTE:     blend_cfg.alpha_byte = data[1:0];
			REG_BLANKET_ALPHA:  blend_cfg.blanket_alpha = data[7:0];
			REG_DST_OPAQUE:     blend_cfg.dst_opaque = data[0];
			REG_DST_COLOR_MASK: blend_cfg.dst_color_mask = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_config();
		send_pixels('0, '0);
		send_pixels('1, '1);
		send_pixels(EDGE_SRC, EDGE_DST);
		send_random_pixels();
	endtask

	task automatic test_opaque_dst();
		cfg_write(REG_BLEND_MODE, 32'(MODE_OPAQUE));
		send_pixels(EDGE_SRC, EDGE_DST);
		cfg_write(REG_DST_COLOR_MASK, '1);
		send_pixels(EDGE_SRC, EDGE_DST);
		cfg_write(REG_DST_COLOR_MASK, '0);
		send_pixels('1, '1);
		cfg_write(REG_DST_COLOR_MASK, 32'hFF00FF00);
		send_random_pixels();
	endtask

	task automatic test_alpha_position();
		cfg_write(REG_BLEND_MODE, 32'd1);
		for (int p = 0; p < 3; p++) begin
			cfg_write(REG_ALPHA_BYTE, 32'(p));
			send_pixels(EDGE_SRC, EDGE_DST);
		end
	endtask

	task automatic test_surface_alpha();
		cfg_write(REG_ALPHA_BYTE, 32'd3);
		cfg_write(REG_BLEND_MODE, 32'd2);
		cfg_write(REG_BLANKET_ALPHA, 32'd0);
		send_pixels(EDGE_SRC, EDGE_DST);
		cfg_write(REG_BLANKET_ALPHA, 32'(FULL_ALPHA));
		cfg_write(REG_DST_OPAQUE, 32'd1);
		send_pixels(EDGE_SRC, EDGE_DST);
		cfg_write(REG_BLANKET_ALPHA, 32'h80);
		cfg_write(REG_DST_OPAQUE, 32'd0);
		send_pixels(EDGE_SRC, EDGE_DST);
	endtask

	task automatic test_mode_three();
		cfg_write(REG_BLEND_MODE, 32'd3);
		cfg_write(REG_BLANKET_ALPHA, 32'h40);
		cfg_write(REG_DST_OPAQUE, 32'd1);
		send_pixels(EDGE_SRC, EDGE_DST);
		cfg_write(REG_DST_OPAQUE, 32'd0);
		send_random_pixels();
	endtask

	task automatic test_ignored_index();
		for (int k = 1; k <= 3; k++)
			cfg_write(CFG_INDEX_W'(REG_DST_COLOR_MASK) + CFG_INDEX_W'(k), '1);
		send_pixels(EDGE_SRC, EDGE_DST);
	endtask

	task automatic test_random_blend();
		logic [7:0]  blanket;
		logic [31:0] mask;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(0, 3))
				0: blanket = 8'h00;
				1: blanket = FULL_ALPHA;
				default: blanket = 8'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: mask = '0;
				1: mask = '1;
				2: mask = CFG_RESET.dst_color_mask;
				default: mask = $urandom;
			endcase
			cfg_write(REG_BLEND_MODE, {30'($urandom), 2'($urandom_range(0, 3))});
			cfg_write(REG_ALPHA_BYTE, {30'($urandom), 2'($urandom_range(0, 3))});
			cfg_write(REG_BLANKET_ALPHA, {24'($urandom), blanket});
			cfg_write(REG_DST_OPAQUE, {31'($urandom), 1'($urandom_range(0, 1))});
			cfg_write(REG_DST_COLOR_MASK, mask);
			if ($urandom_range(0, 3) == 0)
				cfg_write(CFG_INDEX_W'(REG_DST_COLOR_MASK) +
					CFG_INDEX_W'($urandom_range(1, 3)), $urandom);
			quiet = (p >= RAND_PHASES - 2) || ($urandom_range(0, 4) == 0);
			repeat (ITEMS_PER_PHASE) send_random_pixels();
		end
	endtask

	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_blends.size() == 0) begin
				report_mismatch($sformatf("result word %h with none predicted", res_word));
			end else begin
				want = pending_blends.pop_front();
				if (res_word.out_pair_lo !== want.out_pair_lo)
					report_mismatch($sformatf("out_pair_lo %h, predicted %h",
						res_word.out_pair_lo, want.out_pair_lo));
				if (res_word.out_pair_hi !== want.out_pair_hi)
					report_mismatch($sformatf("out_pair_hi %h, predicted %h",
						res_word.out_pair_hi, want.out_pair_hi));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("straight_alpha_pixel_blend regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		blend_cfg = CFG_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_config();
		test_opaque_dst();
		test_alpha_position();
		test_surface_alpha();
		test_mode_three();
		test_ignored_index();
		test_random_blend();
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("straight_alpha_pixel_blend regression: pass");
		else
			$display("straight_alpha_pixel_blend regression: fail");
		$finish;
	end

endmodule
